// ===== hw/rtl/sbmc_pkg.sv =====
// shared types, constants and saturation helpers for the bass mono crossover
package sbmc_pkg;

  localparam int MAX_STAGES      = 4;
  localparam int SAMPLE_BITS     = 24;
  localparam int COEFF_FRAC_BITS = 18;

  localparam int ACC_W       = 32;
  localparam int WIDE_W      = 64;
  localparam int PROD_W      = ACC_W + COEFF_FRAC_BITS + 2;
  localparam int NUM_PATHS   = 4;
  localparam int PATH_W      = 2;
  localparam int STG_W       = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int STG_CNT_W   = $clog2(MAX_STAGES + 1);
  localparam int ZDEPTH      = NUM_PATHS * MAX_STAGES;
  localparam int ZA_W        = $clog2(ZDEPTH);

  localparam int STAGE_CNT_W = 3;
  localparam int CHAN_CNT_W  = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = COEFF_FRAC_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_POLE_COEFF    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam logic [COEFF_FRAC_BITS-1:0] POLE_RESET   = COEFF_FRAC_BITS'(257045);
  localparam logic [STAGE_CNT_W-1:0]     STAGES_RESET = 3'd2;
  localparam logic [CHAN_CNT_W-1:0]      CHANS_RESET  = 4'd2;
  localparam logic [CHAN_CNT_W-1:0]      CHANS_STEREO = 4'd2;

  localparam logic [PATH_W-1:0] PATH_LOW_L  = 2'd0;
  localparam logic [PATH_W-1:0] PATH_LOW_R  = 2'd1;
  localparam logic [PATH_W-1:0] PATH_HIGH_L = 2'd2;
  localparam logic [PATH_W-1:0] PATH_HIGH_R = 2'd3;

  localparam logic signed [WIDE_W-1:0] ACC_MAX = WIDE_W'({1'b0, {(ACC_W-1){1'b1}}});
  localparam logic signed [WIDE_W-1:0] ACC_MIN = ~ACC_MAX;
  localparam logic signed [WIDE_W-1:0] SMP_MAX = WIDE_W'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
  localparam logic signed [WIDE_W-1:0] SMP_MIN = ~SMP_MAX;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic                          block_last;
  } sbmc_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          block_last_out;
  } sbmc_out_t;

  typedef struct packed {
    logic            clr;
    logic            we;
    logic [ZA_W-1:0] addr;
  } sbmc_zctl_t;

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] res;
    if (v > ACC_MAX) begin
      res = ACC_MAX;
    end else if (v < ACC_MIN) begin
      res = ACC_MIN;
    end else begin
      res = v;
    end
    return res[ACC_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(
    input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] res;
    if (v > SMP_MAX) begin
      res = SMP_MAX;
    end else if (v < SMP_MIN) begin
      res = SMP_MIN;
    end else begin
      res = v;
    end
    return res[SAMPLE_BITS-1:0];
  endfunction

endpackage

// ===== hw/rtl/sbmc_pole_unit.sv =====
// shared one-pole update unit: registered multiply, then round, shift and saturate
module sbmc_pole_unit
  import sbmc_pkg::*;
(
  input  logic                              clk,
  input  logic                              mul_en,
  input  logic signed [ACC_W-1:0]           x,
  input  logic signed [ACC_W-1:0]           z,
  input  logic        [COEFF_FRAC_BITS-1:0] b,
  output logic signed [ACC_W-1:0]           y_low,
  output logic signed [ACC_W-1:0]           y_high
);

  localparam logic signed [WIDE_W-1:0] RND = WIDE_W'(1) <<< (COEFF_FRAC_BITS - 1);

  logic signed [ACC_W:0]      diff;
  logic signed [PROD_W-1:0]   prod_nxt;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [WIDE_W-1:0]   sum;
  logic signed [WIDE_W-1:0]   shifted;

  // a*x + b*z rewritten as x*2^F + b*(z - x)
  always_comb begin
    diff     = (ACC_W+1)'(z) - (ACC_W+1)'(x);
    prod_nxt = PROD_W'(diff) * PROD_W'(signed'({1'b0, b}));
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  always_comb begin
    sum     = (WIDE_W'(x) <<< COEFF_FRAC_BITS) + WIDE_W'(prod_r) + RND;
    shifted = sum >>> COEFF_FRAC_BITS;
    y_low   = sat_acc(shifted);
    y_high  = sat_acc(WIDE_W'(x) - WIDE_W'(y_low));
  end

endmodule

// ===== hw/rtl/sbmc_zbank.sv =====
// stage memory bank for all four split paths, cleared by reset or filter writes
module sbmc_zbank
  import sbmc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  sbmc_zctl_t              ctl,
  input  logic signed [ACC_W-1:0] wdata,
  output logic signed [ACC_W-1:0] rdata
);

  logic signed [ACC_W-1:0] mem_r [ZDEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      for (int i = 0; i < ZDEPTH; i++) begin
        mem_r[i] <= '0;
      end
    end else if (ctl.we) begin
      mem_r[ctl.addr] <= wdata;
    end
  end

  assign rdata = mem_r[ctl.addr];

endmodule

// ===== hw/rtl/stereo_bass_mono_crossover_core.sv =====
// top level: sequencer, configuration registers and output register
// an active stereo frame runs four path updates per stage, n stages, on the shared pole unit,
// n being the clamped stage count: each update is a multiply state then an accumulate state,
// sixteen updates at most, then a mix state that waits for the output register; no new request until idle
// a mono frame (channel count below two) goes straight to the mix state
// rst_n is synchronous: control and config registers reset, stage memories clear at once
module stereo_bass_mono_crossover_core
  import sbmc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sbmc_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sbmc_out_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ACC  = 2'd2;
  localparam logic [1:0] ST_MIX  = 2'd3;

  logic [1:0]                 state_r, state_nxt;
  logic [STG_W-1:0]           stg_r, stg_nxt;
  logic [PATH_W-1:0]          path_r, path_nxt;
  logic                       byp_r, byp_nxt;
  logic                       ov_r, ov_nxt;
  logic [COEFF_FRAC_BITS-1:0] pole_r, pole_nxt;
  logic [STAGE_CNT_W-1:0]     stcnt_r, stcnt_nxt;
  logic [CHAN_CNT_W-1:0]      chcnt_r, chcnt_nxt;
  sbmc_in_t                   in_r, in_nxt;
  sbmc_out_t                  out_r, out_nxt;
  logic signed [ACC_W-1:0]    work_r [NUM_PATHS];
  logic signed [ACC_W-1:0]    work_nxt [NUM_PATHS];

  sbmc_zctl_t                 zctl;
  logic                       mul_en;
  logic signed [ACC_W-1:0]    zrd;
  logic signed [ACC_W-1:0]    y_low;
  logic signed [ACC_W-1:0]    y_high;
  logic [STG_CNT_W-1:0]       n_eff;
  logic                       last_stage;
  logic signed [ACC_W:0]      mid;

  sbmc_pole_unit u_pole (
    .clk    (clk),
    .mul_en (mul_en),
    .x      (work_r[path_r]),
    .z      (zrd),
    .b      (pole_r),
    .y_low  (y_low),
    .y_high (y_high)
  );

  sbmc_zbank u_zbank (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (zctl),
    .wdata (y_low),
    .rdata (zrd)
  );

  always_comb begin
    if (stcnt_r == '0) begin
      n_eff = STG_CNT_W'(1);
    end else if ((STG_CNT_W + STAGE_CNT_W)'(stcnt_r) > (STG_CNT_W + STAGE_CNT_W)'(MAX_STAGES)) begin
      n_eff = STG_CNT_W'(MAX_STAGES);
    end else begin
      n_eff = STG_CNT_W'(stcnt_r);
    end
    last_stage = ((STG_CNT_W'(stg_r) + STG_CNT_W'(1)) == n_eff);
    mid        = ((ACC_W+1)'(work_r[PATH_LOW_L]) + (ACC_W+1)'(work_r[PATH_LOW_R])) >>> 1;
  end

  always_comb begin
    state_nxt = state_r;
    stg_nxt   = stg_r;
    path_nxt  = path_r;
    byp_nxt   = byp_r;
    ov_nxt    = ov_r && !out_ready;
    pole_nxt  = pole_r;
    stcnt_nxt = stcnt_r;
    chcnt_nxt = chcnt_r;
    in_nxt    = in_r;
    out_nxt   = out_r;
    work_nxt  = work_r;
    mul_en    = 1'b0;
    zctl.clr  = 1'b0;
    zctl.we   = 1'b0;
    zctl.addr = ZA_W'({stg_r, path_r});

    if (cfg_valid) begin
      case (cfg_index)
        REG_POLE_COEFF: begin
          pole_nxt = cfg_data;
          zctl.clr = 1'b1;
        end
        REG_STAGE_COUNT: begin
          stcnt_nxt = cfg_data[STAGE_CNT_W-1:0];
          zctl.clr  = 1'b1;
        end
        REG_CHANNEL_COUNT: begin
          chcnt_nxt = cfg_data[CHAN_CNT_W-1:0];
        end
        default: begin
        end
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          in_nxt = in_data;
          work_nxt[PATH_LOW_L]  = ACC_W'(in_data.left_in);
          work_nxt[PATH_LOW_R]  = ACC_W'(in_data.right_in);
          work_nxt[PATH_HIGH_L] = ACC_W'(in_data.left_in);
          work_nxt[PATH_HIGH_R] = ACC_W'(in_data.right_in);
          stg_nxt  = '0;
          path_nxt = PATH_LOW_L;
          if (chcnt_r < CHANS_STEREO) begin
            byp_nxt   = 1'b1;
            state_nxt = ST_MIX;
          end else begin
            byp_nxt   = 1'b0;
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        mul_en    = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        zctl.we   = 1'b1;
        work_nxt[path_r] = (path_r == PATH_HIGH_L || path_r == PATH_HIGH_R) ? y_high : y_low;
        state_nxt = ST_MUL;
        if (path_r == PATH_HIGH_R) begin
          path_nxt = PATH_LOW_L;
          if (last_stage) begin
            state_nxt = ST_MIX;
          end else begin
            stg_nxt = stg_r + STG_W'(1);
          end
        end else begin
          path_nxt = path_r + PATH_W'(1);
        end
      end
      ST_MIX: begin
        if (!ov_r || out_ready) begin
          if (byp_r) begin
            out_nxt.left_out  = in_r.left_in;
            out_nxt.right_out = in_r.right_in;
          end else begin
            out_nxt.left_out  = sat_smp(WIDE_W'(mid) + WIDE_W'(work_r[PATH_HIGH_L]));
            out_nxt.right_out = sat_smp(WIDE_W'(mid) + WIDE_W'(work_r[PATH_HIGH_R]));
          end
          out_nxt.block_last_out = in_r.block_last;
          ov_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      stg_r   <= '0;
      path_r  <= PATH_LOW_L;
      byp_r   <= 1'b0;
      ov_r    <= 1'b0;
      pole_r  <= POLE_RESET;
      stcnt_r <= STAGES_RESET;
      chcnt_r <= CHANS_RESET;
    end else begin
      state_r <= state_nxt;
      stg_r   <= stg_nxt;
      path_r  <= path_nxt;
      byp_r   <= byp_nxt;
      ov_r    <= ov_nxt;
      pole_r  <= pole_nxt;
      stcnt_r <= stcnt_nxt;
      chcnt_r <= chcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r   <= in_nxt;
    out_r  <= out_nxt;
    work_r <= work_nxt;
  end

  assign in_ready  = rst_n && (state_r == ST_IDLE);
  assign cfg_ready = rst_n;
  assign out_valid = ov_r;
  assign out_data  = out_r;

endmodule

// ===== hw/rtl/sbmc_checker.sv =====
// port-level checker for the crossover core, bound to the top level
module sbmc_checker
  import sbmc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input sbmc_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while a frame is in work");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a finished frame");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind stereo_bass_mono_crossover_core sbmc_checker u_sbmc_checker (.*);

// ===== bench/stereo_bass_mono_crossover_core_tb.sv =====
// self-checking bench for the bass mono crossover core with a bit-exact frame predictor
module stereo_bass_mono_crossover_core_tb;
  import sbmc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic signed [SAMPLE_BITS-1:0] PEAK_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] PEAK_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam int STYLE_LOUD  = 0;
  localparam int STYLE_QUIET = 1;
  localparam int STYLE_NOISE = 2;
  localparam int SETTLE_CYCLES = 8 * MAX_STAGES + 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASES        = 10;
  localparam int PHASE_FRAMES  = 100;
  localparam int SHOW_LIMIT    = 20;

  class crossover_scoreboard;
    logic [COEFF_FRAC_BITS-1:0] coeff_b;
    logic [STAGE_CNT_W-1:0]     n_stages;
    logic [CHAN_CNT_W-1:0]      n_chans;
    int                         mem[NUM_PATHS][MAX_STAGES];
    sbmc_out_t                  expected_frames[$];
    int                         compared;
    int                         mismatches;

    function new();
      coeff_b    = POLE_RESET;
      n_stages   = STAGES_RESET;
      n_chans    = CHANS_RESET;
      compared   = 0;
      mismatches = 0;
      clear_memories();
    endfunction

    function void clear_memories();
      foreach (mem[p, s]) mem[p][s] = 0;
    endfunction

    function longint clip(longint v, int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function longint pole_step(logic [PATH_W-1:0] path, int st, longint x);
      longint b;
      longint a;
      longint acc;
      longint y;
      b   = longint'(coeff_b);
      a   = (longint'(1) <<< COEFF_FRAC_BITS) - b;
      acc = a * x + b * longint'(mem[path][st]) + (longint'(1) <<< (COEFF_FRAC_BITS - 1));
      y   = clip(acc >>> COEFF_FRAC_BITS, ACC_W);
      mem[path][st] = int'(y);
      return y;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_POLE_COEFF: begin
          coeff_b = val[COEFF_FRAC_BITS-1:0];
          clear_memories();
        end
        REG_STAGE_COUNT: begin
          n_stages = val[STAGE_CNT_W-1:0];
          clear_memories();
        end
        REG_CHANNEL_COUNT: begin
          n_chans = val[CHAN_CNT_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function void note_frame(sbmc_in_t f);
      longint    l;
      longint    r;
      longint    llo;
      longint    rlo;
      longint    lhi;
      longint    rhi;
      longint    mid;
      longint    ol;
      longint    orr;
      int        n;
      sbmc_out_t e;
      l  = $signed(f.left_in);
      r  = $signed(f.right_in);
      ol = l;
      orr = r;
      if (n_chans >= CHANS_STEREO) begin
        n = int'(n_stages);
        if (n < 1) n = 1;
        if (n > MAX_STAGES) n = MAX_STAGES;
        llo = l;
        rlo = r;
        lhi = l;
        rhi = r;
        for (int i = 0; i < n; i++) begin
          llo = pole_step(PATH_LOW_L, i, llo);
          rlo = pole_step(PATH_LOW_R, i, rlo);
          lhi = clip(lhi - pole_step(PATH_HIGH_L, i, lhi), ACC_W);
          rhi = clip(rhi - pole_step(PATH_HIGH_R, i, rhi), ACC_W);
        end
        mid = (llo + rlo) >>> 1;
        ol  = clip(mid + lhi, SAMPLE_BITS);
        orr = clip(mid + rhi, SAMPLE_BITS);
      end
      e.left_out       = ol[SAMPLE_BITS-1:0];
      e.right_out      = orr[SAMPLE_BITS-1:0];
      e.block_last_out = f.block_last;
      expected_frames.push_back(e);
    endfunction

    function void check_frame(sbmc_out_t got);
      sbmc_out_t e;
      if (expected_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("%0t: unexpected result %h with nothing outstanding", $time, got);
        return;
      end
      e = expected_frames.pop_front();
      compared++;
      if (got.left_out !== e.left_out || got.right_out !== e.right_out ||
          got.block_last_out !== e.block_last_out) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("%0t: mismatch exp L=%0d R=%0d last=%0b got L=%0d R=%0d last=%0b",
                   $time, e.left_out, e.right_out, e.block_last_out,
                   got.left_out, got.right_out, got.block_last_out);
      end
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  sbmc_in_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  sbmc_out_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  crossover_scoreboard board;
  bit no_idle   = 1'b0;
  bit hold_go   = 1'b0;
  bit hold_done = 1'b0;
  int frames_sent = 0;
  int settings    = 0;

  stereo_bass_mono_crossover_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [SAMPLE_BITS-1:0] pick_sample(int style);
    case (style)
      STYLE_LOUD:  return $urandom_range(1) ? PEAK_POS : PEAK_NEG;
      STYLE_QUIET: return SAMPLE_BITS'(int'($urandom_range(2000)) - 1000);
      default:     return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic offer_frame(input logic [SAMPLE_BITS-1:0] l, input logic [SAMPLE_BITS-1:0] r,
                             input logic last);
    sbmc_in_t f;
    f.left_in    = l;
    f.right_in   = r;
    f.block_last = last;
    if (!no_idle && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_frame(f);
    frames_sent++;
  endtask

  // stop offering and let every outstanding request come back, then allow for the pipeline
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // result side: random back-pressure plus one long hold-off
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) board.check_frame(out_data);
      if (hold_go && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      out_ready <= no_idle || ($urandom_range(99) >= 31);
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] word;
    int                    style;
    board     = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, extremes of both samples and the block end flag
    offer_frame(PEAK_POS, PEAK_POS, 1'b0);
    offer_frame(PEAK_NEG, PEAK_NEG, 1'b1);
    offer_frame(PEAK_POS, PEAK_NEG, 1'b0);
    offer_frame(PEAK_NEG, PEAK_POS, 1'b1);
    offer_frame('0, '0, 1'b0);
    offer_frame(SAMPLE_BITS'(1), SAMPLE_BITS'(-1), 1'b1);

    // unknown register must not disturb the filter memories
    wait_quiet();
    write_setting(REG_UNUSED, CFG_DATA_W'($urandom));
    offer_frame(PEAK_POS, '0, 1'b0);

    // zero coefficient, longest cascade
    wait_quiet();
    write_setting(REG_POLE_COEFF, '0);
    write_setting(REG_STAGE_COUNT, CFG_DATA_W'(MAX_STAGES));
    offer_frame(PEAK_POS, PEAK_NEG, 1'b1);
    offer_frame(SAMPLE_BITS'(12345), SAMPLE_BITS'(-54321), 1'b0);
    offer_frame(PEAK_NEG, PEAK_POS, 1'b0);

    // largest coefficient, stage count zero acts as one
    wait_quiet();
    write_setting(REG_POLE_COEFF, {CFG_DATA_W{1'b1}});
    write_setting(REG_STAGE_COUNT, {{(CFG_DATA_W-STAGE_CNT_W){1'b1}}, {STAGE_CNT_W{1'b0}}});
    offer_frame(PEAK_POS, PEAK_POS, 1'b0);
    offer_frame(PEAK_POS, PEAK_POS, 1'b1);

    // stage count above the maximum
    wait_quiet();
    write_setting(REG_STAGE_COUNT, CFG_DATA_W'(7));
    offer_frame(PEAK_NEG, PEAK_NEG, 1'b0);
    offer_frame(PEAK_NEG, PEAK_NEG, 1'b0);

    // mono streams pass through and leave the memories alone, then the largest channel count runs stereo
    wait_quiet();
    write_setting(REG_CHANNEL_COUNT, '0);
    offer_frame(PEAK_POS, PEAK_NEG, 1'b1);
    offer_frame(SAMPLE_BITS'(-5), SAMPLE_BITS'(5), 1'b0);
    wait_quiet();
    write_setting(REG_CHANNEL_COUNT, CFG_DATA_W'(1));
    offer_frame(PEAK_NEG, PEAK_POS, 1'b0);
    offer_frame(SAMPLE_BITS'(777), SAMPLE_BITS'(-777), 1'b1);
    wait_quiet();
    write_setting(REG_CHANNEL_COUNT, {{(CFG_DATA_W-CHAN_CNT_W){1'b0}}, {CHAN_CNT_W{1'b1}}});
    offer_frame(PEAK_POS, PEAK_POS, 1'b0);
    offer_frame(SAMPLE_BITS'(-100), SAMPLE_BITS'(100), 1'b1);
    settings = 7;

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_quiet();
      if (phase == 0 || $urandom_range(1)) begin
        case ($urandom_range(5))
          0:       word = '0;
          1:       word = {CFG_DATA_W{1'b1}};
          2:       word = CFG_DATA_W'($urandom_range(262143, 240000));
          default: word = CFG_DATA_W'($urandom);
        endcase
        write_setting(REG_POLE_COEFF, word);
      end
      if (phase == 0 || $urandom_range(1)) begin
        word = CFG_DATA_W'($urandom);
        word[STAGE_CNT_W-1:0] = STAGE_CNT_W'($urandom_range(7));
        write_setting(REG_STAGE_COUNT, word);
      end
      if (phase == 0 || $urandom_range(3) != 0) begin
        word = CFG_DATA_W'($urandom);
        word[CHAN_CNT_W-1:0] = ($urandom_range(9) < 2) ? CHAN_CNT_W'($urandom_range(1))
                                                       : CHAN_CNT_W'($urandom_range(15, 2));
        write_setting(REG_CHANNEL_COUNT, word);
      end
      if ($urandom_range(4) == 0) write_setting(REG_UNUSED, CFG_DATA_W'($urandom));
      settings++;
      no_idle = (phase == 3);
      if (phase == 5) hold_go = 1'b1;
      for (int i = 0; i < PHASE_FRAMES; i++) begin
        case ($urandom_range(9))
          0, 1:    style = STYLE_LOUD;
          2, 3:    style = STYLE_QUIET;
          default: style = STYLE_NOISE;
        endcase
        offer_frame(pick_sample(style), pick_sample(style), 1'($urandom_range(1)));
      end
      // end-of-phase pause in phase 7 until every request has come back
      if (phase == 7) begin
        in_valid <= 1'b0;
        while (board.pending() > 0) @(posedge clk);
      end
    end
    no_idle = 1'b0;

    in_valid <= 1'b0;
    for (int k = 0; k < 4000 && board.pending() > 0; k++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.pending() > 0) begin
      $display("%0t: %0d expected results never arrived", $time, board.pending());
      board.mismatches += board.pending();
    end

    $display("run covered %0d frames over %0d filter settings, mono and stereo, 0 to 7 stages",
             frames_sent, settings);
    $display("%0d results compared, %0d mismatches", board.compared, board.mismatches);
    if (board.mismatches == 0) begin
      $display("** stereo_bass_mono_crossover_core: PASSED **");
    end else begin
      $display("** stereo_bass_mono_crossover_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", board.pending());
    $display("** stereo_bass_mono_crossover_core: FAILED **");
    $finish;
  end

endmodule
